@@ rtl/led_pattern_generator_macros.svh @@
// Assertion macros used by the checker file.
`ifndef LED_PATTERN_GENERATOR_MACROS_SVH
`define LED_PATTERN_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define LPG_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("led pattern generator: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset
`define LPG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("led pattern generator: next-cycle check failed");

`endif

@@ rtl/lpg_pkg.sv @@
package lpg_pkg;

	// Default pattern timing
	localparam int unsigned RAMP_STEPS_DEF = 150;
	localparam int unsigned PWM_PERIOD_DEF = 10;

	// State widths
	localparam int unsigned SEG_W   = 2;
	localparam int unsigned TICKS_W = 10;
	localparam int unsigned RAMP_W  = 8;
	localparam int unsigned PWM_W   = 4;
	localparam int unsigned CFG_W   = 3;

	// Segment lengths of the fixed-length patterns
	localparam logic [TICKS_W-1:0] LEN_GAP      = TICKS_W'(500);
	localparam logic [TICKS_W-1:0] LEN_SLOW     = TICKS_W'(1000);
	localparam logic [TICKS_W-1:0] LEN_FAST     = TICKS_W'(200);
	localparam logic [TICKS_W-1:0] LEN_PULSE_OFF = TICKS_W'(900);
	localparam logic [TICKS_W-1:0] LEN_DBL_OFF  = TICKS_W'(700);
	localparam logic [TICKS_W-1:0] LEN_SHORT    = TICKS_W'(100);

	typedef enum logic [2:0] {
		PAT_BREATHE = 3'd0,
		PAT_SLOW    = 3'd1,
		PAT_FAST    = 3'd2,
		PAT_PULSE   = 3'd3,
		PAT_DOUBLE  = 3'd4,
		PAT_ON      = 3'd5,
		PAT_OFF     = 3'd6
	} pattern_t;

	typedef enum logic [0:0] {
		REG_PATTERN    = 1'b0,
		REG_ACTIVE_LOW = 1'b1
	} reg_index_t;

	// Step request from the input stage to the pattern core
	typedef struct packed {
		logic en;
		logic tick;
	} step_req_t;

	// Pattern position; duty tracks floor(ramp*PWM_PERIOD/RAMP_STEPS), dacc the remainder
	typedef struct packed {
		logic [SEG_W-1:0]   seg;
		logic [TICKS_W-1:0] ticks;
		logic [RAMP_W-1:0]  ramp;
		logic [PWM_W-1:0]   pwm;
		logic [RAMP_W-1:0]  dacc;
		logic [PWM_W-1:0]   duty;
	} pat_state_t;

	// Length of a fixed segment
	function automatic logic [TICKS_W-1:0] seg_len(pattern_t pat, logic [SEG_W-1:0] seg);
		logic [TICKS_W-1:0] len;
		len = '0;
		unique case (pat)
			PAT_BREATHE: len = seg[0] ? LEN_GAP : '0;
			PAT_SLOW:    len = LEN_SLOW;
			PAT_FAST:    len = LEN_FAST;
			PAT_PULSE:   len = seg[0] ? LEN_SHORT : LEN_PULSE_OFF;
			PAT_DOUBLE:  len = (seg == '0) ? LEN_DBL_OFF : LEN_SHORT;
			default:     len = '0;
		endcase
		return len;
	endfunction

endpackage

@@ rtl/lpg_core.sv @@
module lpg_core #(
	parameter int unsigned RAMP_STEPS = lpg_pkg::RAMP_STEPS_DEF,
	parameter int unsigned PWM_PERIOD = lpg_pkg::PWM_PERIOD_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [0:0]               cfg_index,
	input  logic [lpg_pkg::CFG_W-1:0] cfg_data,
	input  lpg_pkg::step_req_t       req,
	output logic                     lit,
	output logic                     active_low
);

	localparam int unsigned RAMP_W = lpg_pkg::RAMP_W;
	localparam int unsigned PWM_W  = lpg_pkg::PWM_W;
	localparam logic [RAMP_W-1:0] RAMP_LIM = RAMP_W'(RAMP_STEPS);
	localparam logic [PWM_W-1:0]  PWM_LIM  = PWM_W'(PWM_PERIOD);
	// per ramp step the duty grows by DUTY_Q plus a carry from the remainder
	localparam logic [PWM_W-1:0]  DUTY_Q   = PWM_W'(PWM_PERIOD / RAMP_STEPS);
	localparam logic [RAMP_W:0]   DUTY_R   = (RAMP_W+1)'(PWM_PERIOD % RAMP_STEPS);

	lpg_pkg::pattern_t   pattern_q;
	logic                active_low_q;
	lpg_pkg::pat_state_t st_q;
	lpg_pkg::pat_state_t st_nx;

	logic [PWM_W-1:0]              pwm_inc;
	logic [RAMP_W-1:0]             ramp_inc;
	logic [RAMP_W:0]               dacc_sum;
	logic [lpg_pkg::TICKS_W-1:0]   ticks_inc;

	// LED level at the current position
	always_comb begin
		lit = 1'b0;
		unique case (pattern_q)
			lpg_pkg::PAT_BREATHE: begin
				if (st_q.seg[0])
					lit = 1'b0;
				else if (st_q.seg[1])
					lit = st_q.pwm < (PWM_LIM - st_q.duty);
				else
					lit = st_q.pwm < st_q.duty;
			end
			lpg_pkg::PAT_SLOW, lpg_pkg::PAT_FAST, lpg_pkg::PAT_PULSE,
			lpg_pkg::PAT_DOUBLE: lit = st_q.seg[0];
			lpg_pkg::PAT_ON:     lit = 1'b1;
			default:             lit = 1'b0;
		endcase
	end

	// Advance by one tick
	always_comb begin
		st_nx     = st_q;
		pwm_inc   = st_q.pwm + PWM_W'(1);
		ramp_inc  = st_q.ramp + RAMP_W'(1);
		dacc_sum  = {1'b0, st_q.dacc} + DUTY_R;
		ticks_inc = st_q.ticks + lpg_pkg::TICKS_W'(1);
		if (req.en && req.tick) begin
			if (pattern_q == lpg_pkg::PAT_BREATHE && !st_q.seg[0]) begin
				// ramp segment: PWM period, then ramp step
				if (pwm_inc >= PWM_LIM) begin
					st_nx.pwm = '0;
					if (ramp_inc >= RAMP_LIM) begin
						st_nx.ramp = '0;
						st_nx.dacc = '0;
						st_nx.duty = '0;
						st_nx.seg  = st_q.seg + lpg_pkg::SEG_W'(1);
					end else begin
						st_nx.ramp = ramp_inc;
						if (dacc_sum >= {1'b0, RAMP_LIM}) begin
							st_nx.dacc = RAMP_W'(dacc_sum - {1'b0, RAMP_LIM});
							st_nx.duty = st_q.duty + DUTY_Q + PWM_W'(1);
						end else begin
							st_nx.dacc = dacc_sum[RAMP_W-1:0];
							st_nx.duty = st_q.duty + DUTY_Q;
						end
					end
				end else begin
					st_nx.pwm = pwm_inc;
				end
			end else if (pattern_q <= lpg_pkg::PAT_DOUBLE) begin
				// fixed-length segment
				if (ticks_inc >= lpg_pkg::seg_len(pattern_q, st_q.seg)) begin
					st_nx       = '0;
					st_nx.seg   = st_q.seg + lpg_pkg::SEG_W'(1);
				end else begin
					st_nx.ticks = ticks_inc;
				end
			end
		end
	end

	// Config and state registers; a pattern write restarts the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q    <= lpg_pkg::PAT_OFF;
			active_low_q <= 1'b0;
			st_q         <= '0;
		end else if (cfg_we) begin
			if (lpg_pkg::reg_index_t'(cfg_index) == lpg_pkg::REG_PATTERN) begin
				pattern_q <= lpg_pkg::pattern_t'(cfg_data);
				st_q      <= '0;
			end else begin
				active_low_q <= cfg_data[0];
			end
		end else begin
			st_q <= st_nx;
		end
	end

	assign active_low = active_low_q;

endmodule

@@ rtl/led_pattern_generator.sv @@
// A tick request passes the input register, then the result register, where the pattern
// core updates its counters. Throughput: one request per cycle unless out_ready stalls.
// The result register lets a new request in while the previous result waits for out_ready.
// Reset (arst_n low, async): pattern steady off, active high, position cleared,
// both stages empty.
module led_pattern_generator #(
	parameter int unsigned RAMP_STEPS = lpg_pkg::RAMP_STEPS_DEF,
	parameter int unsigned PWM_PERIOD = lpg_pkg::PWM_PERIOD_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [lpg_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      tick,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      pin_level,
	output logic                      lit
);

	logic               valid_s1;
	logic               tick_s1;
	logic               out_valid_q;
	logic               pin_q;
	logic               lit_q;
	logic               step;
	logic               core_lit;
	logic               core_active_low;
	lpg_pkg::step_req_t req;

	// Stage 1 moves into the result register when that register is free or being read
	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;
	assign req.en   = step;
	assign req.tick = tick_s1;

	lpg_core #(
		.RAMP_STEPS (RAMP_STEPS),
		.PWM_PERIOD (PWM_PERIOD)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req        (req),
		.lit        (core_lit),
		.active_low (core_active_low)
	);

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tick_s1 <= tick;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			lit_q <= core_lit;
			pin_q <= core_lit ^ core_active_low;
		end
	end

	assign out_valid = out_valid_q;
	assign pin_level = pin_q;
	assign lit       = lit_q;

endmodule

@@ rtl/lpg_checker.sv @@
`include "led_pattern_generator_macros.svh"

module lpg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic pin_level,
	input logic lit
);

	// A held result stays valid and unchanged
	`LPG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pin_level) && $stable(lit))

	// Input back-pressure only comes from a stalled result
	`LPG_ASSERT_IMPL(a_stall_src, !in_ready, out_valid && !out_ready)

	// A request accepted into the input register is followed by a valid result
	`LPG_ASSERT_IMPL(a_latency, $past(in_valid && in_ready, 2), out_valid)

endmodule

bind led_pattern_generator lpg_checker u_lpg_checker (.*);

@@ tb/led_pattern_generator_test.sv @@
`timescale 1ns / 1ps

module led_pattern_generator_test;

	localparam int unsigned RAMP_STEPS   = lpg_pkg::RAMP_STEPS_DEF;
	localparam int unsigned PWM_PERIOD   = lpg_pkg::PWM_PERIOD_DEF;
	localparam int unsigned IDLE_PCT     = 7;
	localparam int unsigned SETTLE_TICKS = 4;

	// Segment lengths in ticks
	localparam int unsigned GAP_TICKS       = 500;
	localparam int unsigned SLOW_TICKS      = 1000;
	localparam int unsigned FAST_TICKS      = 200;
	localparam int unsigned PULSE_OFF_TICKS = 900;
	localparam int unsigned DBL_OFF_TICKS   = 700;
	localparam int unsigned SHORT_TICKS     = 100;

	localparam logic ROW_CFG = 1'b1;
	localparam logic ROW_REQ = 1'b0;

	typedef struct packed {
		logic pin;
		logic lit;
	} led_level_t;

	// One directed row: a register write or a request, with an optional typed-in result
	typedef struct packed {
		logic                      is_cfg;
		lpg_pkg::reg_index_t       idx;
		logic [lpg_pkg::CFG_W-1:0] data;
		logic                      tk;
		logic                      typed;
		logic                      e_pin;
		logic                      e_lit;
	} dir_row_t;

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      cfg_we    = 1'b0;
	logic [0:0]                cfg_index = 1'b0;
	logic [lpg_pkg::CFG_W-1:0] cfg_data  = '0;
	logic                      in_valid  = 1'b0;
	logic                      in_ready;
	logic                      tick      = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      pin_level;
	logic                      lit;

	// Pattern state mirrored by the predictor
	lpg_pkg::pattern_t           model_pat;
	logic                        model_al;
	logic [lpg_pkg::SEG_W-1:0]   model_seg;
	logic [lpg_pkg::TICKS_W-1:0] model_ticks;
	logic [lpg_pkg::RAMP_W-1:0]  model_ramp;
	logic [lpg_pkg::PWM_W-1:0]   model_pwm;

	led_level_t  pending_levels[$];
	int unsigned requests_sent  = 0;
	int unsigned ticks_advanced = 0;
	int unsigned levels_checked = 0;
	int unsigned lit_seen       = 0;
	int unsigned mismatches     = 0;
	logic        no_stall       = 1'b0;

	dir_row_t directed_rows [28] = '{
		// after reset: steady off, active high
		'{ROW_REQ, lpg_pkg::REG_PATTERN, 3'd0, 1'b0, 1'b1, 1'b0, 1'b0},
		'{ROW_REQ, lpg_pkg::REG_PATTERN, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0},
		'{ROW_CFG, lpg_pkg::REG_ACTIVE_LOW, 3'd1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_REQ, lpg_pkg::REG_PATTERN, 3'd0, 1'b1, 1'b1, 1'b1, 1'b0},
		'{ROW_CFG, lpg_pkg::REG_PATTERN, lpg_pkg::PAT_ON, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_REQ, lpg_pkg::REG_PATTERN, 3'd0, 1'b1, 1'b1, 1'b0, 1'b1},
		'{ROW_CFG, lpg_pkg::REG_ACTIVE_LOW, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_REQ, lpg_pkg::REG_PATTERN, 3'd0, 1'b0, 1'b1, 1'b1, 1'b1},
		// breathe starts at zero duty
		'{ROW_CFG, lpg_pkg::REG_PATTERN, lpg_pkg::PAT_BREATHE, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_REQ, lpg_pkg::REG_PATTERN, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0},
		'{ROW_REQ, lpg_pkg::REG_PATTERN, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		// flash patterns open with an off segment
		'{ROW_CFG, lpg_pkg::REG_PATTERN, lpg_pkg::PAT_SLOW, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_REQ, lpg_pkg::REG_PATTERN, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0},
		'{ROW_CFG, lpg_pkg::REG_PATTERN, lpg_pkg::PAT_FAST, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_REQ, lpg_pkg::REG_PATTERN, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0},
		'{ROW_REQ, lpg_pkg::REG_PATTERN, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0},
		'{ROW_CFG, lpg_pkg::REG_PATTERN, lpg_pkg::PAT_PULSE, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_REQ, lpg_pkg::REG_PATTERN, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0},
		'{ROW_CFG, lpg_pkg::REG_PATTERN, lpg_pkg::PAT_DOUBLE, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_REQ, lpg_pkg::REG_PATTERN, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0},
		// active low with steady patterns; rewrite of same pattern
		'{ROW_CFG, lpg_pkg::REG_ACTIVE_LOW, 3'd1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_CFG, lpg_pkg::REG_PATTERN, lpg_pkg::PAT_OFF, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_REQ, lpg_pkg::REG_PATTERN, 3'd0, 1'b1, 1'b1, 1'b1, 1'b0},
		'{ROW_CFG, lpg_pkg::REG_PATTERN, lpg_pkg::PAT_ON, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_CFG, lpg_pkg::REG_PATTERN, lpg_pkg::PAT_ON, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_REQ, lpg_pkg::REG_PATTERN, 3'd0, 1'b0, 1'b1, 1'b0, 1'b1},
		// only bit 0 of the polarity write counts
		'{ROW_CFG, lpg_pkg::REG_ACTIVE_LOW, 3'b110, 1'b0, 1'b0, 1'b0, 1'b0},
		'{ROW_REQ, lpg_pkg::REG_PATTERN, 3'd0, 1'b1, 1'b1, 1'b1, 1'b1}
	};

	led_pattern_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.tick      (tick),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pin_level (pin_level),
		.lit       (lit)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Fixed segment length for the current pattern and segment
	function automatic int unsigned segment_ticks_limit(lpg_pkg::pattern_t pat,
		logic [lpg_pkg::SEG_W-1:0] seg);
		case (pat)
			lpg_pkg::PAT_SLOW:   return SLOW_TICKS;
			lpg_pkg::PAT_FAST:   return FAST_TICKS;
			lpg_pkg::PAT_PULSE:  return seg[0] ? SHORT_TICKS : PULSE_OFF_TICKS;
			lpg_pkg::PAT_DOUBLE: return (seg == '0) ? DBL_OFF_TICKS : SHORT_TICKS;
			default:             return GAP_TICKS;
		endcase
	endfunction

	function automatic void restart_pattern();
		model_seg   = '0;
		model_ticks = '0;
		model_ramp  = '0;
		model_pwm   = '0;
	endfunction

	// LED level for the current position, then advance by one tick if asked
	function automatic led_level_t step_led_model(logic tk);
		led_level_t  level;
		int unsigned duty;
		logic        on;
		on = 1'b0;
		if (model_pat == lpg_pkg::PAT_BREATHE) begin
			duty = (int'(model_ramp) * PWM_PERIOD) / RAMP_STEPS;
			if (duty > PWM_PERIOD)
				duty = PWM_PERIOD;
			if (model_seg == 2'd0)
				on = (model_pwm < duty);
			else if (model_seg == 2'd2)
				on = (model_pwm < PWM_PERIOD - duty);
		end else if (model_pat == lpg_pkg::PAT_ON) begin
			on = 1'b1;
		end else if (model_pat <= lpg_pkg::PAT_DOUBLE) begin
			on = model_seg[0];
		end
		level.lit = on;
		level.pin = on ^ model_al;

		// steady patterns and the unused selector hold their position
		if (tk && model_pat <= lpg_pkg::PAT_DOUBLE) begin
			if (model_pat == lpg_pkg::PAT_BREATHE && !model_seg[0]) begin
				// ramp: step through PWM periods, then ramp steps
				model_pwm = model_pwm + 1'b1;
				if (model_pwm >= PWM_PERIOD) begin
					model_pwm  = '0;
					model_ramp = model_ramp + 1'b1;
					if (model_ramp >= RAMP_STEPS) begin
						model_ramp = '0;
						model_seg  = model_seg + 1'b1;
					end
				end
			end else begin
				model_ticks = model_ticks + 1'b1;
				if (model_ticks >= segment_ticks_limit(model_pat, model_seg)) begin
					model_ticks = '0;
					model_ramp  = '0;
					model_pwm   = '0;
					model_seg   = model_seg + 1'b1;
				end
			end
		end
		return level;
	endfunction

	// Register write; returns only after write enable is dropped, so write enable is never re-raised in the same step
	task automatic write_reg(lpg_pkg::reg_index_t idx, logic [lpg_pkg::CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lpg_pkg::REG_PATTERN) begin
			model_pat = lpg_pkg::pattern_t'(data);
			restart_pattern();
		end else begin
			model_al = data[0];
		end
		@(posedge clk);
	endtask

	// Drop valid and wait for every pending result, plus pipeline settling
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic send_request(logic tk, logic typed, led_level_t typed_level);
		led_level_t predicted;
		if (!no_stall && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		tick     <= tk;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = step_led_model(tk);
		pending_levels.push_back(typed ? typed_level : predicted);
		requests_sent++;
		if (tk)
			ticks_advanced++;
		no_stall = (requests_sent >= 300 && requests_sent < 600);
	endtask

	// Result check against the oldest expectation
	always @(posedge clk) begin
		led_level_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_levels.size() == 0) begin
				$error("unexpected result: pin_level=%0b lit=%0b", pin_level, lit);
				mismatches++;
			end else begin
				want = pending_levels.pop_front();
				if (pin_level !== want.pin) begin
					$error("pin_level: expected %0b, got %0b", want.pin, pin_level);
					mismatches++;
				end
				if (lit !== want.lit) begin
					$error("lit: expected %0b, got %0b", want.lit, lit);
					mismatches++;
				end
				levels_checked++;
				if (want.lit)
					lit_seen++;
			end
		end
	end

	// Output back-pressure
	always @(posedge clk)
		out_ready <= no_stall ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);

	initial begin
		lpg_pkg::pattern_t plan_pat [8];
		int unsigned       plan_len [8];
		logic              plan_restart [8];
		logic              al;
		led_level_t        none;

		plan_pat     = '{lpg_pkg::PAT_FAST, lpg_pkg::PAT_FAST, lpg_pkg::PAT_BREATHE,
			lpg_pkg::PAT_PULSE, lpg_pkg::PAT_DOUBLE, lpg_pkg::PAT_SLOW,
			lpg_pkg::PAT_ON, lpg_pkg::PAT_OFF};
		plan_len     = '{350, 420, 170, 20, 20, 20, 20, 20};
		plan_restart = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
		none         = '0;

		model_pat = lpg_pkg::PAT_OFF;
		model_al  = 1'b0;
		restart_pattern();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				drain_results();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				send_request(directed_rows[i].tk, directed_rows[i].typed,
					'{directed_rows[i].e_pin, directed_rows[i].e_lit});
			end
		end

		// Random phases; the second fast phase keeps position and flips polarity
		foreach (plan_pat[p]) begin
			drain_results();
			if (plan_restart[p]) begin
				al = 1'($urandom_range(1));
				write_reg(lpg_pkg::REG_PATTERN, plan_pat[p]);
			end else begin
				al = ~model_al;
			end
			write_reg(lpg_pkg::REG_ACTIVE_LOW, {2'($urandom_range(3)), al});
			repeat (plan_len[p])
				send_request($urandom_range(99) >= 6, 1'b0, none);
		end

		drain_results();
		$display("Sent %0d requests (%0d advancing) over all seven patterns, both polarities",
			requests_sent, ticks_advanced);
		$display("Checked %0d results, %0d of them with the LED lit", levels_checked, lit_seen);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
